/* rtl/core/bezier_spline_control_points_core_macros.svh */
// Assertion macros shared by the spline control point core.
// Needs nothing but a clock and an active-low reset in the including module.
`ifndef BEZIER_SPLINE_CONTROL_POINTS_CORE_MACROS_SVH
`define BEZIER_SPLINE_CONTROL_POINTS_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BSC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("spline core: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define BSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("spline core: next-cycle check failed");

`endif

/* rtl/core/bsc_pkg.sv */
// Package of the spline control point core: widths, iterative unit types, helpers.
// Used by bsc_divsqrt and bezier_spline_control_points_core; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package bsc_pkg;
  localparam int unsigned CoordW    = 16;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned TanW      = 18;
  localparam int unsigned NumW      = 62;
  localparam int unsigned DenW      = 32;
  localparam int unsigned QuoW      = 48;
  localparam int unsigned DivSteps  = 48;
  localparam int unsigned SqrtSteps = 31;

  typedef enum logic {
    OP_DIV,
    OP_SQRT
  } du_op_e;

  typedef struct packed {
    logic              start;
    du_op_e            op;
    logic [NumW-1:0]   num;
    logic [DenW-1:0]   den;
  } du_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [QuoW-1:0]   result;
  } du_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > 50'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -50'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [1:0] sgn64(input logic signed [63:0] v);
    logic signed [1:0] r;
    if (v > 64'sd0) begin
      r = 2'sb01;
    end else if (v < 64'sd0) begin
      r = 2'sb11;
    end else begin
      r = 2'sb00;
    end
    return r;
  endfunction
endpackage
`default_nettype wire

/* rtl/core/bsc_divsqrt.sv */
// Shared iterative unit: restoring division one quotient bit a cycle, or
// integer square root one result bit a cycle. Depends on bsc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bsc_divsqrt (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire bsc_pkg::du_req_t req_i,
  output bsc_pkg::du_rsp_t      rsp_o
);
  import bsc_pkg::*;

  logic                busy_q, done_q;
  du_op_e              op_q;
  logic [5:0]          cnt_q;
  logic [33:0]         rem_q;
  logic [QuoW-1:0]     quo_q;
  logic [NumW-1:0]     work_q;
  logic [DenW-1:0]     den_q;
  logic [33:0]         shv, trial;
  logic                take;

  always_comb begin
    if (op_q == OP_SQRT) begin
      shv   = {rem_q[31:0], work_q[NumW-1 -: 2]};
      trial = {1'b0, quo_q[30:0], 2'b01};
    end else begin
      shv   = {rem_q[32:0], work_q[NumW-1]};
      trial = {2'b00, den_q};
    end
    take = (shv >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_DIV;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      work_q <= '0;
      den_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (!busy_q && req_i.start) begin
        busy_q <= 1'b1;
        op_q   <= req_i.op;
        rem_q  <= '0;
        quo_q  <= '0;
        den_q  <= req_i.den;
        if (req_i.op == OP_SQRT) begin
          work_q <= req_i.num;
          cnt_q  <= 6'(SqrtSteps);
        end else begin
          work_q <= {req_i.num[QuoW-1:0], (NumW-QuoW)'(0)};
          cnt_q  <= 6'(DivSteps);
        end
      end else if (busy_q) begin
        rem_q <= take ? (shv - trial) : shv;
        quo_q <= {quo_q[QuoW-2:0], take};
        work_q <= (op_q == OP_SQRT) ? {work_q[NumW-3:0], 2'b00} : {work_q[NumW-2:0], 1'b0};
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.busy   = busy_q;
  assign rsp_o.done   = done_q;
  assign rsp_o.result = quo_q;
endmodule
`default_nettype wire

/* rtl/core/bezier_spline_control_points_core.sv */
// Cubic Bezier spline control points on one shared divide and square root unit: a unit
// vector takes a normalising shift, a square root and two divisions, a zero vector none,
// and a segment's output arithmetic a multiply and a division for each of four offsets.
// A point is taken only in idle, so the input waits while a point is worked on, output
// stalls included; one word at a time.
// Reset is asynchronous, active low, and clears the sequence and the threshold to 1.
`timescale 1ns / 1ps
`default_nettype none
`include "bezier_spline_control_points_core_macros.svh"
module bezier_spline_control_points_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [7:0]   cfg_wdata_i,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [31:0]  s_axis_tdata_i,  // point_x, point_y
  input  wire logic         s_axis_tlast_i,  // last_point
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  output logic [191:0]      m_axis_tdata_o,  // start_x, start_y, ctrl1_x, ctrl1_y,
                                             // ctrl2_x, ctrl2_y, end_x, end_y
  output logic              m_axis_tlast_o,  // last_segment
  output logic              m_axis_tuser_o   // status
);
  import bsc_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISPATCH, ST_ERR_OUT,
    ST_U_INIT, ST_U_NORM, ST_U_SQ1, ST_U_SQ2, ST_U_SQ3, ST_U_SQRT,
    ST_U_DIVA, ST_U_WAITA, ST_U_DIVB, ST_U_WAITB, ST_U_END,
    ST_E_INIT, ST_E_M1, ST_E_M2, ST_E_M3, ST_E_M4, ST_E_M5, ST_E_M6,
    ST_E_M7, ST_E_M8, ST_E_M9, ST_E_M10, ST_E_M11,
    ST_E_OMUL, ST_E_ODIV, ST_E_OWAIT, ST_E_OUT
  } state_e;

  typedef enum logic [2:0] {
    PH_CHORD0, PH_NEW, PH_TAN, PH_EMIT1, PH_EMIT2
  } phase_e;

  state_e state_q;
  phase_e phase_q;
  logic [7:0] eps_q;
  logic [1:0] seen_q;
  logic signed [15:0] olx_q, oly_q, nwx_q, nwy_q, px_q, py_q;
  logic plast_q;
  logic signed [TanW-1:0] cdx_q, cdy_q, ltx_q, lty_q, nx_q, ny_q;
  logic signed [18:0] ia_q, ib_q;
  logic [29:0] ua_q, ub_q;
  logic usa_q, usb_q;
  logic [30:0] r_q;
  logic [16:0] qa_q, qb_q;
  logic signed [15:0] ex0_q, ey0_q, ex1_q, ey1_q;
  logic signed [TanW-1:0] elx_q, ely_q, erx_q, ery_q;
  logic elast_q, lbig_q, rbig_q, cross_q, pneg_q;
  logic signed [17:0] n1_q, n2_q;
  logic [18:0] d1_q, d2_q;
  logic signed [63:0] acc_q, nn_q, p_q;
  logic signed [1:0] s1_q, s2_q;
  logic [1:0] k_q;
  logic signed [31:0] ofs_q [4];
  logic signed [15:0] ostx_q, osty_q, oex_q, oey_q;
  logic signed [31:0] oc_q [4];
  logic ovalid_q, olast_q, ostat_q;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  du_req_t du_req;
  du_rsp_t du_rsp;
  logic signed [16:0] dx, dy;
  logic signed [17:0] sx, sy;
  logic [17:0] mlx, mrx;
  logic signed [TanW-1:0] tk;
  logic signed [17:0] nk;
  logic [18:0] dk;
  logic signed [15:0] bk;
  logic subk;
  logic [63:0] pm;
  logic signed [49:0] offv, valk;
  logic slot_free, c1pos, c2pos, out_load;
  logic signed [1:0] snn, cmpv;
  logic signed [63:0] diffv;

  bsc_divsqrt u_divsqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (du_req),
    .rsp_o  (du_rsp)
  );

  function automatic logic [17:0] mag18(input logic signed [17:0] v);
    return v[17] ? 18'(-v) : 18'(v);
  endfunction

  function automatic logic [18:0] mag19(input logic signed [18:0] v);
    return v[18] ? 19'(-v) : 19'(v);
  endfunction

  assign dx  = $signed({ex1_q[15], ex1_q}) - $signed({ex0_q[15], ex0_q});
  assign dy  = $signed({ey1_q[15], ey1_q}) - $signed({ey0_q[15], ey0_q});
  assign sx  = usa_q ? -$signed({1'b0, qa_q}) : $signed({1'b0, qa_q});
  assign sy  = usb_q ? -$signed({1'b0, qb_q}) : $signed({1'b0, qb_q});
  assign mlx = mag18(elx_q);
  assign mrx = mag18(erx_q);
  assign pm  = p_q[63] ? 64'(-p_q) : 64'(p_q);
  assign slot_free = !ovalid_q || m_axis_tready_i;
  assign out_load = slot_free && (state_q inside {ST_ERR_OUT, ST_E_OUT});
  assign mul_p = mul_a * mul_b;
  assign diffv = acc_q - p_q;
  assign snn = sgn64(nn_q);
  assign cmpv = sgn64(diffv);
  assign c1pos = (mlx != 18'd0) && (s1_q != 2'sb00) && (snn != 2'sb00)
                 && ((elx_q[17] ^ s1_q[1] ^ snn[1]) == 1'b0);
  assign c2pos = (mrx != 18'd0) && (s2_q != 2'sb00) && (snn != 2'sb00)
                 && ((erx_q[17] ^ s2_q[1] ^ snn[1]) == 1'b0);

  always_comb begin
    case (k_q)
      2'd0: begin tk = elx_q; nk = n1_q; dk = d1_q; bk = ex0_q; subk = 1'b0; end
      2'd1: begin tk = ely_q; nk = n1_q; dk = d1_q; bk = ey0_q; subk = 1'b0; end
      2'd2: begin tk = erx_q; nk = n2_q; dk = d2_q; bk = ex1_q; subk = 1'b1; end
      default: begin tk = ery_q; nk = n2_q; dk = d2_q; bk = ey1_q; subk = 1'b1; end
    endcase
    offv = pneg_q ? -$signed({2'b00, du_rsp.result}) : $signed({2'b00, du_rsp.result});
    valk = ($signed(50'(bk)) <<< 8) + (subk ? -offv : offv);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_U_SQ1:  begin mul_a = $signed({2'b00, ua_q}); mul_b = $signed({2'b00, ua_q}); end
      ST_U_SQ2:  begin mul_a = $signed({2'b00, ub_q}); mul_b = $signed({2'b00, ub_q}); end
      ST_E_M1:   begin mul_a = 32'(ely_q); mul_b = 32'(erx_q); end
      ST_E_M2:   begin mul_a = 32'(ery_q); mul_b = 32'(elx_q); end
      ST_E_M3:   begin mul_a = $signed({24'd0, eps_q}); mul_b = $signed({14'd0, mlx}); end
      ST_E_M4:   begin mul_a = p_q[31:0]; mul_b = $signed({14'd0, mrx}); end
      ST_E_M5:   begin mul_a = 32'(dy); mul_b = 32'(erx_q); end
      ST_E_M6:   begin mul_a = 32'(ery_q); mul_b = 32'(dx); end
      ST_E_M7:   begin mul_a = 32'(ely_q); mul_b = 32'(dx); end
      ST_E_M8:   begin mul_a = 32'(dy); mul_b = 32'(elx_q); end
      ST_E_M9:   begin mul_a = 32'(n1_q); mul_b = $signed({13'd0, d2_q}); end
      ST_E_M10:  begin mul_a = 32'(n2_q); mul_b = $signed({13'd0, d1_q}); end
      ST_E_OMUL: begin mul_a = 32'(tk); mul_b = 32'(nk); end
      default:   begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_comb begin
    du_req.start = 1'b0;
    du_req.op    = OP_DIV;
    du_req.num   = '0;
    du_req.den   = '0;
    case (state_q)
      ST_U_SQ3: begin
        du_req.start = 1'b1;
        du_req.op    = OP_SQRT;
        du_req.num   = acc_q[NumW-1:0] + p_q[NumW-1:0];
      end
      ST_U_DIVA: begin
        du_req.start = 1'b1;
        du_req.num   = NumW'({ua_q, 16'd0}) + NumW'(r_q >> 1);
        du_req.den   = DenW'(r_q);
      end
      ST_U_DIVB: begin
        du_req.start = 1'b1;
        du_req.num   = NumW'({ub_q, 16'd0}) + NumW'(r_q >> 1);
        du_req.den   = DenW'(r_q);
      end
      ST_E_ODIV: begin
        du_req.start = 1'b1;
        du_req.num   = NumW'({pm[39:0], 8'd0}) + NumW'(dk >> 1);
        du_req.den   = DenW'(dk);
      end
      default: du_req.start = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_CHORD0;
      eps_q <= 8'd1;
      seen_q <= '0;
      olx_q <= '0; oly_q <= '0; nwx_q <= '0; nwy_q <= '0; px_q <= '0; py_q <= '0;
      plast_q <= 1'b0;
      cdx_q <= '0; cdy_q <= '0; ltx_q <= '0; lty_q <= '0; nx_q <= '0; ny_q <= '0;
      ia_q <= '0; ib_q <= '0; ua_q <= '0; ub_q <= '0; usa_q <= 1'b0; usb_q <= 1'b0;
      r_q <= '0; qa_q <= '0; qb_q <= '0;
      ex0_q <= '0; ey0_q <= '0; ex1_q <= '0; ey1_q <= '0;
      elx_q <= '0; ely_q <= '0; erx_q <= '0; ery_q <= '0;
      elast_q <= 1'b0; lbig_q <= 1'b0; rbig_q <= 1'b0; cross_q <= 1'b0; pneg_q <= 1'b0;
      n1_q <= '0; n2_q <= '0; d1_q <= '0; d2_q <= '0;
      acc_q <= '0; nn_q <= '0; p_q <= '0; s1_q <= '0; s2_q <= '0; k_q <= '0;
      for (int i = 0; i < 4; i++) begin
        ofs_q[i] <= '0;
        oc_q[i] <= '0;
      end
      ostx_q <= '0; osty_q <= '0; oex_q <= '0; oey_q <= '0;
      ovalid_q <= 1'b0; olast_q <= 1'b0; ostat_q <= 1'b0;
    end else begin
      p_q <= mul_p;
      if (cfg_we_i) begin
        eps_q <= cfg_wdata_i;
      end
      if (out_load) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        ovalid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            px_q <= s_axis_tdata_i[15:0];
            py_q <= s_axis_tdata_i[31:16];
            plast_q <= s_axis_tlast_i;
            state_q <= ST_DISPATCH;
          end
        end
        ST_DISPATCH: begin
          if (seen_q == 2'd0) begin
            nwx_q <= px_q;
            nwy_q <= py_q;
            seen_q <= plast_q ? 2'd0 : 2'd1;
            state_q <= plast_q ? ST_ERR_OUT : ST_IDLE;
          end else begin
            ia_q <= 19'(px_q) - 19'(nwx_q);
            ib_q <= 19'(py_q) - 19'(nwy_q);
            phase_q <= (seen_q == 2'd1) ? PH_CHORD0 : PH_NEW;
            state_q <= ST_U_INIT;
          end
        end
        ST_ERR_OUT: begin
          if (slot_free) begin
            ostx_q <= '0; osty_q <= '0; oex_q <= '0; oey_q <= '0;
            for (int i = 0; i < 4; i++) begin
              oc_q[i] <= '0;
            end
            olast_q <= 1'b1;
            ostat_q <= 1'b1;
            seen_q <= 2'd0;
            state_q <= ST_IDLE;
          end
        end
        ST_U_INIT: begin
          ua_q <= 30'(mag19(ia_q));
          ub_q <= 30'(mag19(ib_q));
          usa_q <= ia_q[18];
          usb_q <= ib_q[18];
          qa_q <= '0;
          qb_q <= '0;
          state_q <= (ia_q == 19'sd0 && ib_q == 19'sd0) ? ST_U_END : ST_U_NORM;
        end
        ST_U_NORM: begin
          if (ua_q[29] || ub_q[29]) begin
            state_q <= ST_U_SQ1;
          end else begin
            ua_q <= {ua_q[28:0], 1'b0};
            ub_q <= {ub_q[28:0], 1'b0};
          end
        end
        ST_U_SQ1: state_q <= ST_U_SQ2;
        ST_U_SQ2: begin
          acc_q <= p_q;
          state_q <= ST_U_SQ3;
        end
        ST_U_SQ3: state_q <= ST_U_SQRT;
        ST_U_SQRT: begin
          if (du_rsp.done) begin
            r_q <= du_rsp.result[30:0];
            state_q <= ST_U_DIVA;
          end
        end
        ST_U_DIVA: state_q <= ST_U_WAITA;
        ST_U_WAITA: begin
          if (du_rsp.done) begin
            qa_q <= du_rsp.result[16:0];
            state_q <= ST_U_DIVB;
          end
        end
        ST_U_DIVB: state_q <= ST_U_WAITB;
        ST_U_WAITB: begin
          if (du_rsp.done) begin
            qb_q <= du_rsp.result[16:0];
            state_q <= ST_U_END;
          end
        end
        ST_U_END: begin
          case (phase_q)
            PH_CHORD0: begin
              cdx_q <= sx;
              cdy_q <= sy;
              olx_q <= nwx_q;
              oly_q <= nwy_q;
              nwx_q <= px_q;
              nwy_q <= py_q;
              ltx_q <= '0;
              lty_q <= '0;
              seen_q <= plast_q ? 2'd0 : 2'd2;
              state_q <= plast_q ? ST_ERR_OUT : ST_IDLE;
            end
            PH_NEW: begin
              nx_q <= sx;
              ny_q <= sy;
              ia_q <= 19'(cdx_q) + 19'(sx);
              ib_q <= 19'(cdy_q) + 19'(sy);
              phase_q <= PH_TAN;
              state_q <= ST_U_INIT;
            end
            default: begin
              ex0_q <= olx_q; ey0_q <= oly_q; ex1_q <= nwx_q; ey1_q <= nwy_q;
              elx_q <= ltx_q; ely_q <= lty_q; erx_q <= sx; ery_q <= sy;
              elast_q <= 1'b0;
              phase_q <= PH_EMIT1;
              state_q <= ST_E_INIT;
            end
          endcase
        end
        ST_E_INIT: begin
          lbig_q <= (mlx > 18'(eps_q));
          rbig_q <= (mrx > 18'(eps_q));
          if (dy != 17'sd0 || eps_q == 8'd0) begin
            if (mlx > 18'(eps_q)) begin
              n1_q <= elx_q[17] ? -18'(dx) : 18'(dx);
              d1_q <= {mlx, 1'b0};
            end else begin
              n1_q <= 18'sd1;
              d1_q <= 19'd1 << FracBits;
            end
            if (mrx > 18'(eps_q)) begin
              n2_q <= erx_q[17] ? -18'(dx) : 18'(dx);
              d2_q <= {mrx, 1'b0};
            end else begin
              n2_q <= 18'sd1;
              d2_q <= 19'd1 << FracBits;
            end
          end else begin
            n1_q <= '0; d1_q <= 19'd1;
            n2_q <= '0; d2_q <= 19'd1;
          end
          state_q <= ST_E_M1;
        end
        ST_E_M1: state_q <= ST_E_M2;
        ST_E_M2: begin acc_q <= p_q; state_q <= ST_E_M3; end
        ST_E_M3: begin nn_q <= diffv; state_q <= ST_E_M4; end
        ST_E_M4: state_q <= ST_E_M5;
        ST_E_M5: begin
          cross_q <= ((nn_q[63] ? -nn_q : nn_q) > (p_q >>> FracBits));
          state_q <= ST_E_M6;
        end
        ST_E_M6: begin acc_q <= p_q; state_q <= ST_E_M7; end
        ST_E_M7: begin s1_q <= cmpv; state_q <= ST_E_M8; end
        ST_E_M8: begin acc_q <= p_q; state_q <= ST_E_M9; end
        ST_E_M9: begin s2_q <= cmpv; state_q <= ST_E_M10; end
        ST_E_M10: begin acc_q <= p_q; state_q <= ST_E_M11; end
        ST_E_M11: begin
          if (lbig_q && rbig_q && cross_q && c1pos && c2pos) begin
            if (ely_q > 18'sd0 ? cmpv > 2'sb00 : cmpv < 2'sb00) begin
              n1_q <= '0; d1_q <= 19'd1;
            end else begin
              n2_q <= '0; d2_q <= 19'd1;
            end
          end
          k_q <= 2'd0;
          state_q <= ST_E_OMUL;
        end
        ST_E_OMUL: state_q <= ST_E_ODIV;
        ST_E_ODIV: begin
          pneg_q <= p_q[63];
          state_q <= ST_E_OWAIT;
        end
        ST_E_OWAIT: begin
          if (du_rsp.done) begin
            ofs_q[k_q] <= sat32(valk);
            k_q <= k_q + 2'd1;
            state_q <= (k_q == 2'd3) ? ST_E_OUT : ST_E_OMUL;
          end
        end
        ST_E_OUT: begin
          if (slot_free) begin
            ostx_q <= ex0_q; osty_q <= ey0_q; oex_q <= ex1_q; oey_q <= ey1_q;
            for (int i = 0; i < 4; i++) begin
              oc_q[i] <= ofs_q[i];
            end
            olast_q <= elast_q;
            ostat_q <= 1'b0;
            if (phase_q == PH_EMIT1) begin
              ltx_q <= erx_q; lty_q <= ery_q;
              cdx_q <= nx_q; cdy_q <= ny_q;
              olx_q <= nwx_q; oly_q <= nwy_q;
              nwx_q <= px_q; nwy_q <= py_q;
              if (plast_q) begin
                ex0_q <= nwx_q; ey0_q <= nwy_q; ex1_q <= px_q; ey1_q <= py_q;
                elx_q <= erx_q; ely_q <= ery_q; erx_q <= '0; ery_q <= '0;
                elast_q <= 1'b1;
                phase_q <= PH_EMIT2;
                state_q <= ST_E_INIT;
              end else begin
                state_q <= ST_IDLE;
              end
            end else begin
              seen_q <= 2'd0;
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {oey_q, oex_q, oc_q[3], oc_q[2], oc_q[1], oc_q[0], osty_q, ostx_q};
  assign m_axis_tlast_o  = olast_q;
  assign m_axis_tuser_o  = ostat_q;

  `BSC_ASSERT_IMPL(a_err_is_last, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o, m_axis_tlast_o)
  `BSC_ASSERT_IMPL(a_seen_range, clk_i, rst_ni, 1'b1, seen_q != 2'd3)
  `BSC_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)
  `BSC_ASSERT_IMPL(a_start_when_free, clk_i, rst_ni, du_req.start, !du_rsp.busy)
endmodule
`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for the spline control point core: directed and random point sequences
// are driven on the input stream and each segment is checked against an in-bench predictor.
// Depends only on the core, which in turn needs bsc_divsqrt and bsc_pkg.
`timescale 1ns / 1ps

class spline_scoreboard;
  typedef struct {
    logic signed [15:0] sx, sy, ex, ey;
    logic signed [31:0] c1x, c1y, c2x, c2y;
    logic last, status;
  } segment_t;

  segment_t pending[$];
  int unsigned fails;
  longint eps;
  longint old_x, old_y, new_x, new_y, dir_x, dir_y, lt_x, lt_y;
  int unsigned held;

  function new();
    eps = 1;
    fails = 0;
    held = 0;
    old_x = 0; old_y = 0; new_x = 0; new_y = 0;
    dir_x = 0; dir_y = 0; lt_x = 0; lt_y = 0;
  endfunction

  function automatic longint sgn(longint v);
    return (v > 0) - (v < 0);
  endfunction

  function automatic longint absv(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint root(longint x);
    longint res, b;
    res = 0;
    b = 64'sd1 <<< 62;
    while (b > x) b = b >>> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >>> 1) + b;
      end else begin
        res = res >>> 1;
      end
      b = b >>> 2;
    end
    return res;
  endfunction

  function automatic longint div_near(longint num, longint den);
    longint q;
    q = (absv(num) + den / 2) / den;
    return num < 0 ? -q : q;
  endfunction

  function automatic void direction(longint a, longint b, output longint ox,
                                    output longint oy);
    longint ua, ub, m, r;
    ua = absv(a);
    ub = absv(b);
    m = ua > ub ? ua : ub;
    if (m == 0) begin
      ox = 0;
      oy = 0;
      return;
    end
    while (m < (64'sd1 <<< 29)) begin
      m = m <<< 1; ua = ua <<< 1; ub = ub <<< 1;
    end
    r = root(ua * ua + ub * ub);
    ox = ((ua <<< 16) + r / 2) / r;
    oy = ((ub <<< 16) + r / 2) / r;
    if (a < 0) ox = -ox;
    if (b < 0) oy = -oy;
  endfunction

  function automatic logic signed [31:0] clip(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic segment_t segment(longint x0, longint y0, longint x1, longint y1,
                                       longint lx, longint ly, longint rx, longint ry,
                                       logic last);
    segment_t s;
    longint dx, dy, n1, d1, n2, d2, nn, lim, c1, c2, cmp;
    bit lbig, rbig, drop1;
    dx = x1 - x0;
    dy = y1 - y0;
    lbig = absv(lx) > eps;
    rbig = absv(rx) > eps;
    n1 = 0; d1 = 1; n2 = 0; d2 = 1;
    if ((absv(dy) <<< 16) >= eps) begin
      if (lbig) begin n1 = lx > 0 ? dx : -dx; d1 = 2 * absv(lx); end
      else begin n1 = 1; d1 = 64'sd1 <<< 16; end
      if (rbig) begin n2 = rx > 0 ? dx : -dx; d2 = 2 * absv(rx); end
      else begin n2 = 1; d2 = 64'sd1 <<< 16; end
    end
    if (lbig && rbig) begin
      nn = ly * rx - ry * lx;
      lim = (eps * absv(lx * rx)) >>> 16;
      if (absv(nn) > lim) begin
        c1 = sgn(lx) * sgn(dy * rx - ry * dx) * sgn(nn);
        c2 = sgn(rx) * sgn(ly * dx - dy * lx) * sgn(nn);
        if (c1 > 0 && c2 > 0) begin
          cmp = sgn(n1 * d2 - n2 * d1);
          drop1 = ly > 0 ? cmp > 0 : cmp < 0;
          if (drop1) begin n1 = 0; d1 = 1; end
          else begin n2 = 0; d2 = 1; end
        end
      end
    end
    s.sx = x0[15:0]; s.sy = y0[15:0]; s.ex = x1[15:0]; s.ey = y1[15:0];
    s.c1x = clip(x0 * 256 + div_near(lx * n1 * 256, d1));
    s.c1y = clip(y0 * 256 + div_near(ly * n1 * 256, d1));
    s.c2x = clip(x1 * 256 - div_near(rx * n2 * 256, d2));
    s.c2y = clip(y1 * 256 - div_near(ry * n2 * 256, d2));
    s.last = last;
    s.status = 1'b0;
    return s;
  endfunction

  function automatic void push_short();
    segment_t s;
    s = '{default: 0};
    s.last = 1'b1;
    s.status = 1'b1;
    pending.insert(pending.size(), s);
    held = 0;
  endfunction

  function void note_point(logic signed [15:0] px16, logic signed [15:0] py16,
                           logic last);
    longint px, py, nx, ny, tx, ty;
    px = px16;
    py = py16;
    if (held == 0) begin
      new_x = px; new_y = py; held = 1;
      if (last) push_short();
      return;
    end
    if (held == 1) begin
      direction(px - new_x, py - new_y, dir_x, dir_y);
      old_x = new_x; old_y = new_y; new_x = px; new_y = py;
      lt_x = 0; lt_y = 0; held = 2;
      if (last) push_short();
      return;
    end
    direction(px - new_x, py - new_y, nx, ny);
    direction(dir_x + nx, dir_y + ny, tx, ty);
    pending.insert(pending.size(),
                   segment(old_x, old_y, new_x, new_y, lt_x, lt_y, tx, ty, 1'b0));
    lt_x = tx; lt_y = ty; dir_x = nx; dir_y = ny;
    old_x = new_x; old_y = new_y; new_x = px; new_y = py;
    if (last) begin
      pending.insert(pending.size(),
                     segment(old_x, old_y, new_x, new_y, lt_x, lt_y, 0, 0, 1'b1));
      held = 0;
    end
  endfunction

  function void check_segment(logic [191:0] d, logic last, logic status);
    segment_t e;
    if (pending.size() == 0) begin
      $error("segment word with nothing expected");
      fails++;
      return;
    end
    e = pending.pop_front();
    if (d[15:0] !== e.sx) begin $error("start_x exp %0d got %0d", e.sx, $signed(d[15:0])); fails++; end
    if (d[31:16] !== e.sy) begin $error("start_y exp %0d got %0d", e.sy, $signed(d[31:16])); fails++; end
    if (d[63:32] !== e.c1x) begin $error("ctrl1_x exp %0d got %0d", e.c1x, $signed(d[63:32])); fails++; end
    if (d[95:64] !== e.c1y) begin $error("ctrl1_y exp %0d got %0d", e.c1y, $signed(d[95:64])); fails++; end
    if (d[127:96] !== e.c2x) begin $error("ctrl2_x exp %0d got %0d", e.c2x, $signed(d[127:96])); fails++; end
    if (d[159:128] !== e.c2y) begin $error("ctrl2_y exp %0d got %0d", e.c2y, $signed(d[159:128])); fails++; end
    if (d[175:160] !== e.ex) begin $error("end_x exp %0d got %0d", e.ex, $signed(d[175:160])); fails++; end
    if (d[191:176] !== e.ey) begin $error("end_y exp %0d got %0d", e.ey, $signed(d[191:176])); fails++; end
    if (last !== e.last) begin $error("last_segment exp %0d got %0d", e.last, last); fails++; end
    if (status !== e.status) begin $error("status exp %0d got %0d", e.status, status); fails++; end
  endfunction
endclass

module testbench;
  logic clk_i, rst_ni, cfg_we_i;
  logic [7:0] cfg_wdata_i;
  logic s_axis_tvalid_i, s_axis_tready_o, s_axis_tlast_i;
  logic [31:0] s_axis_tdata_i;
  logic m_axis_tvalid_o, m_axis_tready_i, m_axis_tlast_o, m_axis_tuser_o;
  logic [191:0] m_axis_tdata_o;
  spline_scoreboard segments;
  bit send_calm, recv_calm;
  longint cycles;

  bezier_spline_control_points_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i), .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i(s_axis_tdata_i), .s_axis_tlast_i(s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o), .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o(m_axis_tdata_o), .m_axis_tlast_o(m_axis_tlast_o),
    .m_axis_tuser_o(m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > 64'd8000000) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // The receiver stalls at random except in calm stretches.
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready_i = recv_calm || ($urandom_range(99) >= 25);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      segments.check_segment(m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
  end

  task automatic write_limit(input logic [7:0] v);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    segments.eps = v;
  endtask

  task automatic drain();
    while (segments.pending.size() != 0) @(posedge clk_i);
    repeat (700) @(posedge clk_i);
  endtask

  task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
                            input logic last);
    @(negedge clk_i);
    while (!send_calm && $urandom_range(99) < 25) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i = {y, x};
    s_axis_tlast_i = last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    segments.note_point(x, y, last);
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
  endtask

  function automatic logic [15:0] rand_coord(input int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(200)) - 100);
      2: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      default: return 16'($signed($urandom_range(4000)) - 2000);
    endcase
  endfunction

  task automatic random_sequences(input int n);
    int len, mode, k;
    logic signed [15:0] x, y;
    while (n > 0) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
      mode = $urandom_range(3);
      x = rand_coord(mode);
      y = rand_coord(mode);
      for (k = 0; k < len; k++) begin
        if ($urandom_range(9) == 0) begin
          x = x; y = y;
        end else if ($urandom_range(3) == 0) begin
          y = rand_coord(mode);
        end else begin
          x = rand_coord(mode);
          y = rand_coord(mode);
        end
        send_point(x, y, k == len - 1);
        n--;
      end
    end
  endtask

  initial begin
    segments = new();
    send_calm = 1'b0;
    recv_calm = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 8'd0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = 32'd0;
    s_axis_tlast_i = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: short sequences, repeated and opposite points, flat runs, extremes.
    send_point(16'sd5, -16'sd7, 1'b1);
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd3, 16'sd4, 1'b1);
    send_point(-16'sd32768, -16'sd32768, 1'b0);
    send_point(16'sd32767, 16'sd32767, 1'b0);
    send_point(-16'sd32768, 16'sd32767, 1'b0);
    send_point(16'sd32767, -16'sd32768, 1'b1);
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd10, 16'sd0, 1'b0);
    send_point(16'sd0, 16'sd0, 1'b1);
    send_point(16'sd0, 16'sd5, 1'b0);
    send_point(16'sd10, 16'sd5, 1'b0);
    send_point(16'sd20, 16'sd5, 1'b0);
    send_point(16'sd30, 16'sd9, 1'b1);
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd0, 16'sd100, 1'b0);
    send_point(16'sd1, 16'sd200, 1'b0);
    send_point(-16'sd50, 16'sd0, 1'b0);
    send_point(16'sd60, 16'sd10, 1'b1);
    drain();

    write_limit(8'd0);
    random_sequences(400);
    drain();
    write_limit(8'd255);
    random_sequences(400);
    drain();
    send_calm = 1'b1;
    recv_calm = 1'b1;
    write_limit(8'd1);
    random_sequences(300);
    drain();
    send_calm = 1'b0;
    recv_calm = 1'b0;
    write_limit(8'($urandom_range(2, 254)));
    random_sequences(600);
    drain();

    if (segments.fails == 0 && segments.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/bsc_pkg.sv
rtl/core/bsc_divsqrt.sv
rtl/core/bezier_spline_control_points_core.sv
bench/testbench.sv
